>>> design/assert_macros.svh
// Assertion macros shared by the palette store RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Clocked check, switched off while reset is asserted (active-low reset).
`define PIVS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");
// Clocked check that also holds through reset.
`define PIVS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");
`else
`define PIVS_ASSERT(lbl, clk, rst_n, prop)
`define PIVS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> design/pivs_pkg.sv
// Shared widths, operation codes and the palette chain token type.
`default_nettype none

package pivs_pkg;

    localparam int VAL_W     = 16;   // stored value width
    localparam int IDX_W     = 8;    // palette index width
    localparam int FILL_W    = 9;    // palette fill count width
    localparam int SLOT_IN_W = 12;   // slot_index port width

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Token passed cell to cell along the palette chain.
    typedef struct packed {
        logic             valid;
        logic             search;    // 1: look up / append data, 0: decode idx
        logic             hit;       // search resolved
        logic             appended;  // resolved by taking a free entry
        logic [VAL_W-1:0] data;      // search key, or decoded value
        logic [IDX_W-1:0] idx;       // index to decode, or index found
    } t_tok;

endpackage

`default_nettype wire

>>> design/pivs_cell.sv
// One palette entry with its compare / decode step on the passing token.
`default_nettype none

module pivs_cell #(
    parameter int CELL_IDX = 0
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_load,
    input  wire logic [pivs_pkg::VAL_W-1:0]  i_load_value,
    input  wire pivs_pkg::t_tok              i_tok,
    output pivs_pkg::t_tok                   o_tok
);

    localparam logic [pivs_pkg::IDX_W-1:0] MY_IDX = CELL_IDX[pivs_pkg::IDX_W-1:0];

    logic                       r_used;
    logic [pivs_pkg::VAL_W-1:0] r_value;
    pivs_pkg::t_tok             r_tok;
    pivs_pkg::t_tok             n_tok;
    logic                       w_append;

    always_comb begin
        n_tok    = i_tok;
        w_append = 1'b0;
        if (i_tok.valid) begin
            if (i_tok.search) begin
                if (!i_tok.hit) begin
                    if (r_used && (r_value == i_tok.data)) begin
                        n_tok.hit = 1'b1;
                        n_tok.idx = MY_IDX;
                    end else if (!r_used) begin
                        // first free entry: take the new value here
                        w_append       = 1'b1;
                        n_tok.hit      = 1'b1;
                        n_tok.appended = 1'b1;
                        n_tok.idx      = MY_IDX;
                    end
                end
            end else if (i_tok.idx == MY_IDX) begin
                n_tok.data = r_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= (CELL_IDX == 0);
            r_value <= '0;
            r_tok   <= '0;
        end else begin
            r_tok <= n_tok;
            if (i_load) begin
                r_value <= i_load_value;
            end
            if (w_append) begin
                r_value <= i_tok.data;
                r_used  <= 1'b1;
            end
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

>>> design/pivs_chain.sv
// Row of palette cells; a token advances one cell per cycle.
`default_nettype none

module pivs_chain #(
    parameter int DEPTH = 256
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [pivs_pkg::VAL_W-1:0]  i_cfg_wdata,
    input  wire pivs_pkg::t_tok              i_tok,
    output pivs_pkg::t_tok                   o_tok
);

    pivs_pkg::t_tok w_link [DEPTH+1];

    assign w_link[0] = i_tok;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        // entry 0 carries the empty value register
        pivs_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_load       ((g == 0) ? i_cfg_we : 1'b0),
            .i_load_value (i_cfg_wdata),
            .i_tok        (w_link[g]),
            .o_tok        (w_link[g+1])
        );
    end

    assign o_tok = w_link[DEPTH];

endmodule

`default_nettype wire

>>> design/palette_indexed_value_store.sv
// Top level: palette-encoded 16-bit value store with one-way switch to wide storage.
//
//  Channel | Direction | Handshake                  | Beat contents
//  --------+-----------+----------------------------+----------------------------------------
//  in      | to block  | i_in_valid / o_in_ready    | i_opcode, i_slot_index, i_write_value
//  out     | from block| o_out_valid / i_out_ready  | o_read_value, o_wide_active, o_palette_used
//  cfg     | to block  | i_cfg_we (no wait)         | i_cfg_wdata (empty value)
//
//  Compact mode: a read or write first reads the slot's palette index, then sends a token
//  along the palette cell chain one cell per cycle; from the chain end the result goes
//  through S_OUT to the output register, and the next beat is taken back in S_IDLE.
//  Wide mode: a write goes straight to S_OUT; a read passes S_WRD first (registered slot
//  memory read). A slot index of SLOTS or more goes straight to S_OUT as well.
//  The write that overflows the palette streams every slot through the chain into the
//  wide memory, then stores its own value in S_WFIN before S_OUT.
//  After reset the slot index memory is zeroed slot by slot in S_CLEAR; no beat is taken
//  until then. One beat is in flight at a time; a result waiting in the output
//  register does not block the next accept, only the next result.
`default_nettype none

module palette_indexed_value_store #(
    parameter int SLOTS         = 4096,
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration
    input  wire logic                              i_cfg_we,
    input  wire logic [pivs_pkg::VAL_W-1:0]        i_cfg_wdata,
    // request channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_opcode,
    input  wire logic [pivs_pkg::SLOT_IN_W-1:0]    i_slot_index,
    input  wire logic [pivs_pkg::VAL_W-1:0]        i_write_value,
    // result channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [pivs_pkg::VAL_W-1:0]             o_read_value,
    output logic                                   o_wide_active,
    output logic [pivs_pkg::FILL_W-1:0]            o_palette_used
);

`include "assert_macros.svh"

    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int SLOTS_M1 = SLOTS - 1;

    localparam logic [CNT_W-1:0]            CNT_END   = SLOTS[CNT_W-1:0];
    localparam logic [CNT_W-1:0]            CLR_LAST  = SLOTS_M1[CNT_W-1:0];
    localparam logic [SLOT_W-1:0]           SLOT_LAST = SLOTS_M1[SLOT_W-1:0];
    localparam logic [pivs_pkg::FILL_W-1:0] FILL_MAX  =
        PALETTE_DEPTH[pivs_pkg::FILL_W-1:0];

    // sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;  // zero the index memory after reset
    localparam logic [2:0] S_IDLE  = 3'd1;  // ready for a beat
    localparam logic [2:0] S_IRD   = 3'd2;  // index read back, launch token
    localparam logic [2:0] S_CHAIN = 3'd3;  // wait for token at chain end
    localparam logic [2:0] S_WRD   = 3'd4;  // wide memory read back
    localparam logic [2:0] S_CONV  = 3'd5;  // stream all slots into wide memory
    localparam logic [2:0] S_WFIN  = 3'd6;  // store the overflowing value
    localparam logic [2:0] S_OUT   = 3'd7;  // hand result to output register

    logic [2:0]                    r_state;
    logic [CNT_W-1:0]              r_cnt;       // clear / sweep read counter
    logic [SLOT_W-1:0]             r_wcnt;      // sweep write counter
    logic                          r_sweep_rv;  // sweep read data valid
    logic [pivs_pkg::FILL_W-1:0]   r_fill;
    logic                          r_wide;
    logic [pivs_pkg::VAL_W-1:0]    r_empty;

    // accepted beat
    logic                          r_op;
    logic [SLOT_W-1:0]             r_addr;
    logic [pivs_pkg::VAL_W-1:0]    r_val;
    logic [pivs_pkg::VAL_W-1:0]    r_res;

    // output register
    logic                          r_out_valid;
    logic [pivs_pkg::VAL_W-1:0]    r_out_value;
    logic                          r_out_wide;
    logic [pivs_pkg::FILL_W-1:0]   r_out_used;

    // slot memories
    logic [pivs_pkg::IDX_W-1:0]    r_idx_mem  [SLOTS];
    logic [pivs_pkg::IDX_W-1:0]    r_idx_rdata;
    logic [pivs_pkg::VAL_W-1:0]    r_wide_mem [SLOTS];
    logic [pivs_pkg::VAL_W-1:0]    r_wide_rdata;

    logic [31:0]                   w_slot_ext;
    logic                          w_in_range;
    logic [SLOT_W-1:0]             w_port_addr;
    logic                          w_in_acc;
    logic [SLOT_W-1:0]             w_rd_addr;

    logic                          w_idx_we;
    logic [SLOT_W-1:0]             w_idx_wa;
    logic [pivs_pkg::IDX_W-1:0]    w_idx_wd;
    logic                          w_wide_we;
    logic [SLOT_W-1:0]             w_wide_wa;
    logic [pivs_pkg::VAL_W-1:0]    w_wide_wd;

    pivs_pkg::t_tok                w_tok_in;
    pivs_pkg::t_tok                w_tok_out;

    assign w_slot_ext  = 32'(i_slot_index);
    assign w_in_range  = (w_slot_ext < 32'(SLOTS));
    assign w_port_addr = w_slot_ext[SLOT_W-1:0];
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;

    // one read address serves both memories
    assign w_rd_addr = (r_state == S_CONV) ? r_cnt[SLOT_W-1:0] : w_port_addr;

    // ---------------------------------------------------------------------
    // Memory write controls
    // ---------------------------------------------------------------------
    always_comb begin
        w_idx_we = 1'b0;
        w_idx_wa = r_addr;
        w_idx_wd = w_tok_out.idx;
        if (r_state == S_CLEAR) begin
            w_idx_we = 1'b1;
            w_idx_wa = r_cnt[SLOT_W-1:0];
            w_idx_wd = '0;
        end else if ((r_state == S_CHAIN) && w_tok_out.valid && w_tok_out.search
                     && w_tok_out.hit) begin
            w_idx_we = 1'b1;
        end
    end

    always_comb begin
        w_wide_we = 1'b0;
        w_wide_wa = w_port_addr;
        w_wide_wd = i_write_value;
        case (r_state)
            S_IDLE: begin
                // wide-mode write goes straight in
                w_wide_we = w_in_acc && w_in_range && r_wide
                            && (i_opcode == pivs_pkg::OP_WRITE);
            end
            S_CONV: begin
                w_wide_we = w_tok_out.valid;
                w_wide_wa = r_wcnt;
                w_wide_wd = w_tok_out.data;
            end
            S_WFIN: begin
                w_wide_we = 1'b1;
                w_wide_wa = r_addr;
                w_wide_wd = r_val;
            end
            default: begin
                w_wide_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_idx_we) begin
            r_idx_mem[w_idx_wa] <= w_idx_wd;
        end
        r_idx_rdata <= r_idx_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_wide_we) begin
            r_wide_mem[w_wide_wa] <= w_wide_wd;
        end
        r_wide_rdata <= r_wide_mem[w_rd_addr];
    end

    // ---------------------------------------------------------------------
    // Palette chain
    // ---------------------------------------------------------------------
    always_comb begin
        w_tok_in = '0;
        if (r_state == S_IRD) begin
            w_tok_in.valid  = 1'b1;
            w_tok_in.search = (r_op == pivs_pkg::OP_WRITE);
            w_tok_in.data   = r_val;
            w_tok_in.idx    = r_idx_rdata;
        end else if (r_state == S_CONV) begin
            // one decode token per cycle during the sweep
            w_tok_in.valid = r_sweep_rv;
            w_tok_in.idx   = r_idx_rdata;
        end
    end

    pivs_chain #(
        .DEPTH (PALETTE_DEPTH)
    ) u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_tok       (w_tok_in),
        .o_tok       (w_tok_out)
    );

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_wcnt      <= '0;
            r_sweep_rv  <= 1'b0;
            r_fill      <= pivs_pkg::FILL_W'(1);
            r_wide      <= 1'b0;
            r_empty     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_empty <= i_cfg_wdata;
            end
            // S_OUT handles the output register itself
            if (r_out_valid && i_out_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            r_sweep_rv <= (r_state == S_CONV) && (r_cnt != CNT_END);

            case (r_state)
                S_CLEAR: begin
                    if (r_cnt == CLR_LAST) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_op   <= i_opcode;
                        r_addr <= w_port_addr;
                        r_val  <= i_write_value;
                        if (!w_in_range) begin
                            r_res   <= r_empty;
                            r_state <= S_OUT;
                        end else if (r_wide) begin
                            if (i_opcode == pivs_pkg::OP_WRITE) begin
                                r_res   <= i_write_value;
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_WRD;
                            end
                        end else begin
                            r_state <= S_IRD;
                        end
                    end
                end
                S_WRD: begin
                    r_res   <= r_wide_rdata;
                    r_state <= S_OUT;
                end
                S_IRD: begin
                    r_state <= S_CHAIN;
                end
                S_CHAIN: begin
                    if (w_tok_out.valid) begin
                        if (!w_tok_out.search) begin
                            r_res   <= w_tok_out.data;
                            r_state <= S_OUT;
                        end else if (w_tok_out.hit) begin
                            r_res <= r_val;
                            if (w_tok_out.appended) begin
                                r_fill <= r_fill + pivs_pkg::FILL_W'(1);
                            end
                            r_state <= S_OUT;
                        end else begin
                            // palette full: convert every slot
                            r_cnt   <= '0;
                            r_wcnt  <= '0;
                            r_state <= S_CONV;
                        end
                    end
                end
                S_CONV: begin
                    if (r_cnt != CNT_END) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                    if (w_tok_out.valid) begin
                        r_wcnt <= r_wcnt + SLOT_W'(1);
                        if (r_wcnt == SLOT_LAST) begin
                            r_wide  <= 1'b1;
                            r_state <= S_WFIN;
                        end
                    end
                end
                S_WFIN: begin
                    r_res   <= r_val;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= r_res;
                        r_out_wide  <= r_wide;
                        r_out_used  <= r_wide ? '0 : r_fill;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_value   = r_out_value;
    assign o_wide_active  = r_out_wide;
    assign o_palette_used = r_out_used;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `PIVS_ASSERT(a_wide_sticky, i_clk, i_rst_n, r_wide |=> r_wide)
    `PIVS_ASSERT(a_fill_bound, i_clk, i_rst_n, (r_fill <= FILL_MAX) && (r_fill != '0))
    `PIVS_ASSERT(a_tok_owner, i_clk, i_rst_n,
        w_tok_out.valid |-> ((r_state == S_CHAIN) || (r_state == S_CONV)))
    `PIVS_ASSERT(a_append_room, i_clk, i_rst_n,
        (w_tok_out.valid && w_tok_out.appended) |-> (r_fill < FILL_MAX))

endmodule

`default_nettype wire
